/* rtl/core/assert_macros.svh */
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sctd_pkg.sv */
// Shared constants, codes and types of the sector cache tag directory.
package sctd_pkg;

    localparam int ENTRIES    = 64;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int NUM_W      = $clog2(ENTRIES + 1);
    localparam int DEV_W      = 16;
    localparam int SEC_W      = 32;
    localparam int CFG_W      = 7;
    localparam int SLOT_W     = 6;
    localparam int OP_W       = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE      = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE     = 2'd2;
    localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd3;

    // Running search result handed from cell to cell.
    typedef struct packed {
        logic                  match_found;
        logic [IDX_W-1:0]      match_idx;
        logic [COUNT_BITS-1:0] match_cnt;
        logic                  free_found;
        logic [IDX_W-1:0]      free_idx;
        logic                  min_found;
        logic [IDX_W-1:0]      min_idx;
        logic [COUNT_BITS-1:0] min_cnt;
    } sctd_carry_t;

    // Update command broadcast to every cell.
    typedef struct packed {
        logic              clear_all;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic              clr_en;
        logic [IDX_W-1:0]  clr_idx;
        logic              bump_en;
        logic [IDX_W-1:0]  bump_idx;
        logic              halve;
        logic [DEV_W-1:0]  dev;
        logic [SEC_W-1:0]  sec;
    } sctd_cmd_t;

endpackage

/* rtl/core/sctd_cell.sv */
// One directory entry with its stage of the search chain.
module sctd_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [sctd_pkg::IDX_W-1:0] idx,
    input  logic                      en,
    input  sctd_pkg::sctd_cmd_t       cmd,
    input  sctd_pkg::sctd_carry_t     carry_in,
    output sctd_pkg::sctd_carry_t     carry_out
);
    import sctd_pkg::*;

    logic                  valid_reg;
    logic [DEV_W-1:0]      dev_reg;
    logic [SEC_W-1:0]      sec_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    sctd_carry_t           carry_reg;
    sctd_carry_t           carry_next;
    logic                  key_eq;

    assign key_eq    = (dev_reg == cmd.dev) && (sec_reg == cmd.sec);
    assign carry_out = carry_reg;

    always_comb
    begin
        carry_next = carry_in;
        if (en)
        begin
            if (!carry_in.match_found && valid_reg && key_eq)
            begin
                carry_next.match_found = 1'b1;
                carry_next.match_idx   = idx;
                carry_next.match_cnt   = cnt_reg;
            end
            if (!carry_in.free_found && !valid_reg)
            begin
                carry_next.free_found = 1'b1;
                carry_next.free_idx   = idx;
            end
            // strict less keeps the lowest index on a tie
            if (!carry_in.min_found || (cnt_reg < carry_in.min_cnt))
            begin
                carry_next.min_found = 1'b1;
                carry_next.min_idx   = idx;
                carry_next.min_cnt   = cnt_reg;
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.halve && valid_reg && en)
            cnt_next = cnt_next >> 1;
        if (cmd.bump_en && (cmd.bump_idx == idx))
            cnt_next = cnt_next + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.clear_all)
            valid_reg <= 1'b0;
        else if (cmd.wr_en && (cmd.wr_idx == idx))
            valid_reg <= 1'b1;
        else if (cmd.clr_en && (cmd.clr_idx == idx))
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (!cmd.clear_all)
        begin
            if (cmd.wr_en && (cmd.wr_idx == idx))
            begin
                dev_reg <= cmd.dev;
                sec_reg <= cmd.sec;
                cnt_reg <= '0;
            end
            else
                cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/core/sector_cache_tag_directory_lfu.sv */
// Top level of the sector cache tag directory with use-count replacement.
// Usage:
//   Raise start with operation, device_id and sector_number while busy is
//   low; the item is taken at that edge and busy rises.
//   Lookup, store and remove search the chain of ENTRIES cells: the search
//   result ripples one cell per cycle, then the update is applied and the
//   done strobe follows. Invalidate all skips the search and goes to apply.
//   The result (hit, slot, slot_valid, evicted, full_res) is shown for
//   exactly one cycle with done high; busy is low in that cycle, so the
//   next item may be started then. The receiver cannot stall the block.
//   cfg_we with cfg_data sets the number of usable entries (0 acts as 1,
//   values above ENTRIES act as ENTRIES) and clears every entry; write it
//   only while busy is low.
//   Reset clears all entries and sets the usable count to 64.
module sector_cache_tag_directory_lfu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sctd_pkg::OP_W-1:0]     operation,
    input  logic [sctd_pkg::DEV_W-1:0]    device_id,
    input  logic [sctd_pkg::SEC_W-1:0]    sector_number,
    input  logic                          cfg_we,
    input  logic [sctd_pkg::CFG_W-1:0]    cfg_data,
    output logic                          done,
    output logic                          hit,
    output logic [sctd_pkg::SLOT_W-1:0]   slot,
    output logic                          slot_valid,
    output logic                          evicted,
    output logic                          full_res
);
    import sctd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   scan_cnt_reg;
    logic [OP_W-1:0]    op_reg;
    logic [DEV_W-1:0]   dev_reg;
    logic [SEC_W-1:0]   sec_reg;
    logic [CFG_W-1:0]   cfg_reg;
    logic [NUM_W-1:0]   occ_reg;
    logic [NUM_W-1:0]   occ_next;
    logic [NUM_W-1:0]   usable;
    logic [31:0]        cfg_wide;
    logic               done_reg;
    logic               hit_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               slot_valid_reg;
    logic               evicted_reg;
    logic               full_reg;
    logic               hit_next;
    logic [SLOT_W-1:0]  slot_next;
    logic               slot_valid_next;
    logic               evicted_next;
    sctd_cmd_t          cmd;
    sctd_carry_t        carry [ENTRIES+1];
    sctd_carry_t        res;
    logic               accept;

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign hit        = hit_reg;
    assign slot       = slot_reg;
    assign slot_valid = slot_valid_reg;
    assign evicted    = evicted_reg;
    assign full_res   = full_reg;

    assign cfg_wide = 32'(cfg_reg);

    always_comb
    begin
        if (cfg_wide == 32'd0)
            usable = NUM_W'(1);
        else if (cfg_wide > 32'(ENTRIES))
            usable = NUM_W'(ENTRIES);
        else
            usable = NUM_W'(cfg_wide);
    end

    assign carry[0] = '0;
    assign res      = carry[ENTRIES];

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        sctd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (IDX_W'(i)),
            .en        (NUM_W'(i) < usable),
            .cmd       (cmd),
            .carry_in  (carry[i]),
            .carry_out (carry[i+1])
        );
    end

    // Decide the update from the finished search, invalidate or configuration write.
    always_comb
    begin
        cmd           = '0;
        cmd.dev       = dev_reg;
        cmd.sec       = sec_reg;
        cmd.clear_all = cfg_we;
        occ_next        = occ_reg;
        hit_next        = 1'b0;
        slot_next       = '0;
        slot_valid_next = 1'b0;
        evicted_next    = 1'b0;
        if (state_reg == ST_APPLY)
        begin
            if (op_reg == OP_INVALIDATE)
            begin
                cmd.clear_all = 1'b1;
                occ_next      = '0;
            end
            else if (res.match_found)
            begin
                hit_next        = 1'b1;
                slot_next       = SLOT_W'(res.match_idx);
                slot_valid_next = 1'b1;
                if (op_reg == OP_REMOVE)
                begin
                    cmd.clr_en  = 1'b1;
                    cmd.clr_idx = res.match_idx;
                    if (occ_reg != '0)
                        occ_next = occ_reg - 1'b1;
                end
                else
                begin
                    cmd.bump_en  = 1'b1;
                    cmd.bump_idx = res.match_idx;
                    cmd.halve    = (res.match_cnt == COUNT_MAX);
                end
            end
            else if (op_reg == OP_STORE)
            begin
                slot_valid_next = 1'b1;
                cmd.wr_en       = 1'b1;
                if (res.free_found)
                begin
                    cmd.wr_idx = res.free_idx;
                    occ_next   = occ_reg + 1'b1;
                end
                else
                begin
                    cmd.wr_idx   = res.min_idx;
                    evicted_next = 1'b1;
                end
                slot_next = SLOT_W'(cmd.wr_idx);
            end
        end
        if (cfg_we)
            occ_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            cfg_reg      <= CFG_W'(64);
            occ_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            occ_reg  <= occ_next;
            if (cfg_we)
                cfg_reg <= cfg_data;
            case (state_reg)
                ST_IDLE:
                begin
                    scan_cnt_reg <= '0;
                    if (accept)
                    begin
                        if (operation == OP_INVALIDATE)
                            state_reg <= ST_APPLY;
                        else
                            state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // let the search ripple through every cell
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == IDX_W'(ENTRIES - 1))
                        state_reg <= ST_APPLY;
                end
                ST_APPLY:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            dev_reg <= device_id;
            sec_reg <= sector_number;
        end
        if (state_reg == ST_APPLY)
        begin
            hit_reg        <= hit_next;
            slot_reg       <= slot_next;
            slot_valid_reg <= slot_valid_next;
            evicted_reg    <= evicted_next;
            full_reg       <= (occ_next >= usable);
        end
    end

endmodule

/* rtl/core/sctd_checker.sv */
// Port-level checks of the tag directory, bound to the top level.
`include "assert_macros.svh"

module sctd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        hit,
    input logic [sctd_pkg::SLOT_W-1:0] slot,
    input logic                        slot_valid,
    input logic                        evicted,
    input logic                        full_res
);
    import sctd_pkg::*;

    `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `ASSERT_IMPL(a_done_idle, done, !busy, "result shown while still busy")
    `ASSERT_IMPL(a_no_slot, done && !slot_valid, (slot == '0) && !hit, "stray slot or hit")
    `ASSERT_IMPL(a_evict, done && evicted, slot_valid && !hit && full_res, "bad eviction result")

endmodule

bind sector_cache_tag_directory_lfu sctd_checker u_sctd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .hit        (hit),
    .slot       (slot),
    .slot_valid (slot_valid),
    .evicted    (evicted),
    .full_res   (full_res)
);
